// ----- rtl/msbp_pkg.sv -----
// ----------------------------------------------------------------------------
// msbp_pkg
// Shared types and constants for the MSB-first bit packer.
// ----------------------------------------------------------------------------
package msbp_pkg;

    localparam int VALUE_W        = 64;
    localparam int COUNT_W        = 7;
    localparam int BYTE_W         = 8;
    localparam int MAX_FIELD_BITS = 64;
    localparam int QUEUE_DEPTH    = 2;

    // Bit index that the first bit of a fresh byte fills
    localparam logic [2:0] TOP_BIT_POS = 3'd7;

    // Request operation codes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef struct packed {
        logic               op;
        logic [VALUE_W-1:0] value_bits;
        logic [COUNT_W-1:0] bit_count;
    } t_in_req;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic              last;
    } t_out_req;

    // One packed run of 1 to 8 bytes, first byte in the top bits
    typedef struct packed {
        logic [VALUE_W-1:0] bytes;
        logic [2:0]         last_idx;
    } t_job;

endpackage

// ----- rtl/msbp_front.sv -----
// ----------------------------------------------------------------------------
// msbp_front
// Accepts requests, merges new bits with the pending partial byte and hands
// every run of completed bytes, or a flushed partial byte, to the queue as one job.
// ----------------------------------------------------------------------------
module msbp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  msbp_pkg::t_in_req i_req,
    input  logic             i_q_full,
    output logic             o_push,
    output msbp_pkg::t_job   o_job
);
    import msbp_pkg::*;

    localparam int WIN_W = VALUE_W + BYTE_W;

    logic [BYTE_W-1:0]  r_partial;
    logic [2:0]         r_next_pos;
    logic [BYTE_W-1:0]  n_partial;
    logic [2:0]         n_next_pos;

    logic               accept;
    logic [COUNT_W-1:0] cnt_sat;
    logic [2:0]         fill;
    logic [WIN_W-1:0]   v_aligned;
    logic [WIN_W-1:0]   win;
    logic [WIN_W-1:0]   win_rest;
    logic [COUNT_W-1:0] total;
    logic [3:0]         nbytes;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // Saturate the count and line up the new bits behind the pending ones
    always_comb begin
        cnt_sat   = (i_req.bit_count > COUNT_W'(MAX_FIELD_BITS)) ?
                    COUNT_W'(MAX_FIELD_BITS) : i_req.bit_count;
        fill      = TOP_BIT_POS - r_next_pos;
        v_aligned = {{BYTE_W{1'b0}}, i_req.value_bits} << (COUNT_W'(WIN_W) - cnt_sat);
        win       = {r_partial, {VALUE_W{1'b0}}} | (v_aligned >> fill);
        total     = {4'b0000, fill} + cnt_sat;
        nbytes    = total[6:3];
        win_rest  = win << {nbytes, 3'b000};
    end

    // Classify the request and build the job for the back end
    always_comb begin
        o_push     = 1'b0;
        o_job      = '0;
        n_partial  = r_partial;
        n_next_pos = r_next_pos;
        if (i_req.op == OP_FLUSH) begin
            o_push       = accept && (fill != 3'd0);
            o_job.bytes  = {r_partial, {(VALUE_W-BYTE_W){1'b0}}};
            n_partial    = '0;
            n_next_pos   = TOP_BIT_POS;
        end else begin
            o_push       = accept && (nbytes != 4'd0);
            o_job.bytes  = win[WIN_W-1:BYTE_W];
            o_job.last_idx = 3'(nbytes - 4'd1);
            n_partial    = win_rest[WIN_W-1:VALUE_W];
            n_next_pos   = TOP_BIT_POS - total[2:0];
        end
    end

    // Advance packing state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial  <= '0;
            r_next_pos <= TOP_BIT_POS;
        end else if (accept) begin
            r_partial  <= n_partial;
            r_next_pos <= n_next_pos;
        end
    end

endmodule

// ----- rtl/msbp_queue.sv -----
// ----------------------------------------------------------------------------
// msbp_queue
// Short job queue between front and back, with a registered head entry.
// ----------------------------------------------------------------------------
module msbp_queue #(
    parameter int DEPTH = msbp_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  msbp_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_head_valid,
    output msbp_pkg::t_job o_head
);
    import msbp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             r_head_valid;
    t_job             r_head;

    logic head_load;
    logic mem_rd;
    logic mem_wr;
    logic bypass;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = r_head_valid;
    assign o_head       = r_head;

    // Refill the head when it is empty or taken; bypass the memory when empty
    always_comb begin
        head_load = !r_head_valid || i_pop;
        mem_rd    = head_load && (r_count != '0);
        bypass    = head_load && (r_count == '0) && i_push;
        mem_wr    = i_push && !bypass;
    end

    // Hold queued jobs
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
        if (mem_rd) begin
            r_head <= r_mem[r_rd_ptr];
        end else if (bypass) begin
            r_head <= i_job;
        end
    end

    // Advance pointers, count and head state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
            r_head_valid <= 1'b0;
        end else begin
            if (mem_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (mem_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(mem_wr) - CNT_W'(mem_rd);
            if (head_load) begin
                r_head_valid <= mem_rd || bypass;
            end
        end
    end

endmodule

// ----- rtl/msbp_back.sv -----
// ----------------------------------------------------------------------------
// msbp_back
// Takes jobs from the queue and emits their bytes one per cycle while i_ready
// is high, through an output register, marking the final byte of each job.
// ----------------------------------------------------------------------------
module msbp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  msbp_pkg::t_job     i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output msbp_pkg::t_out_req o_req
);
    import msbp_pkg::*;

    logic               r_job_valid;
    logic [VALUE_W-1:0] r_bytes;
    logic [2:0]         r_idx;
    logic [2:0]         r_last_idx;
    logic               r_out_valid;
    t_out_req           r_out;

    logic out_free;
    logic emit;
    logic at_last;

    assign o_valid = r_out_valid;
    assign o_req   = r_out;

    always_comb begin
        out_free = !r_out_valid || i_ready;
        emit     = out_free && r_job_valid;
        at_last  = (r_idx == r_last_idx);
        o_pop    = i_head_valid && (!r_job_valid || (emit && at_last));
    end

    // Step through the current job and load the next one as it ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (o_pop) begin
                r_job_valid <= 1'b1;
                r_bytes     <= i_head.bytes;
                r_last_idx  <= i_head.last_idx;
                r_idx       <= '0;
            end else if (emit) begin
                r_job_valid <= !at_last;
                r_bytes     <= r_bytes << BYTE_W;
                r_idx       <= r_idx + 3'd1;
            end
            if (emit) begin
                r_out_valid    <= 1'b1;
                r_out.byte_out <= r_bytes[VALUE_W-1 -: BYTE_W];
                r_out.last     <= at_last;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/msb_first_bit_packer.sv -----
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// Variable-width MSB-first bit packer: top level.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready, i_req): an append request carries
// value_bits and bit_count (0..64, larger counts saturate); its low bits go
// into the stream most significant first. A flush request emits the pending
// partial byte, zero padded, when at least one bit is pending.
// Output channel (o_valid / i_ready, o_req): one byte per request, first
// packed bit in bit 7; last marks the final byte caused by one request.
// Flow: the first byte of a request passes the queue head register, the job
// register of the back end and the output register before it shows on
// o_valid. The output stage sends one byte per cycle while i_ready is high,
// and a request occupies it for each byte it completes (0 to 8). Requests
// that complete no byte push no job. A job queue of QUEUE_DEPTH entries plus
// a head register lets requests keep arriving while bytes drain.
// Stall: while i_ready is low the output byte holds; once the queue fills,
// o_ready drops. Reset clears the partial byte and drops all queued bytes.
// ----------------------------------------------------------------------------
module msb_first_bit_packer #(
    parameter int QUEUE_DEPTH = msbp_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  msbp_pkg::t_in_req  i_req,
    output logic               o_valid,
    input  logic               i_ready,
    output msbp_pkg::t_out_req o_req
);
    import msbp_pkg::*;

    logic q_full;
    logic q_push;
    t_job q_job;
    logic q_pop;
    logic q_head_valid;
    t_job q_head;

    msbp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (q_job)
    );

    msbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_job        (q_job),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    msbp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_req        (o_req)
    );

endmodule

// ----- rtl/msbp_checker.sv -----
// ----------------------------------------------------------------------------
// msbp_checker
// Port-level checks for the bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module msbp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input msbp_pkg::t_out_req o_req
);

    // Hold a stalled output byte
    a_stall_hold: assert property (@(posedge i_clk)
        i_rst_n && o_valid && !i_ready |=> !i_rst_n || (o_valid && $stable(o_req)))
        else $error("output request changed while stalled");

    // Drop all pending bytes on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Open the input side after reset
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("input not ready after reset");

endmodule

bind msb_first_bit_packer msbp_checker u_checker (.*);
